/* rtl/core/mtlc_pkg.sv */
// Shared types and constants for the menu thermostat and light controller.
package mtlc_pkg;

	// Field widths
	localparam int LIGHT_BITS = 10;
	localparam int ACT_W      = 3;
	localparam int TEMP_W     = 12;
	localparam int TSP_W      = 8;
	localparam int LSP_W      = 16;
	localparam int DUTY_W     = 8;
	localparam int HYST_W     = 8;

	// Stream payload widths, padded to whole bytes
	localparam int IN_BITS    = TEMP_W + LIGHT_BITS;
	localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS   = 1 + 1 + TSP_W + LSP_W + DUTY_W + 1 + 1 + 1;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_FAN_DUTY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HYST     = 2'd1;

	// Event codes carried on s_tuser
	localparam logic [ACT_W-1:0] ACT_NEXT   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PREV   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SELECT = 3'd2;
	localparam logic [ACT_W-1:0] ACT_START  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_STOP   = 3'd4;
	localparam logic [ACT_W-1:0] ACT_TEMP   = 3'd5;
	localparam logic [ACT_W-1:0] ACT_LIGHT  = 3'd6;

	// Reset values
	localparam logic [DUTY_W-1:0] FAN_DUTY_RESET = 8'd230;
	localparam logic [HYST_W-1:0] HYST_RESET     = 8'd10;
	localparam logic [TSP_W-1:0]  TEMP_SP_RESET  = 8'd50;
	localparam logic [LSP_W-1:0]  LIGHT_SP_RESET = 16'd100;

	// Command queue depth
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Classified event, one flag per kind (all clear for an unused code)
	typedef struct packed {
		logic step_up;
		logic step_dn;
		logic sel;
		logic start;
		logic stop;
		logic temp;
		logic light;
	} kind_t;

	typedef struct packed {
		kind_t                    kind;
		logic signed [TEMP_W-1:0] temp;
		logic [LIGHT_BITS-1:0]    light;
	} cmd_t;

	typedef struct packed {
		logic              report_strobe;
		logic              reading_on;
		logic              lamp;
		logic [DUTY_W-1:0] fan_duty;
		logic [LSP_W-1:0]  light_target;
		logic [TSP_W-1:0]  temp_target;
		logic              submenu_active;
		logic              menu_number;
	} res_t;

endpackage

/* rtl/core/mtlc_front.sv */
// Front end: accepts events from the input stream and classifies them.
module mtlc_front (
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [mtlc_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic [mtlc_pkg::ACT_W-1:0]       s_tuser,
	input  logic                             q_ready,
	output logic                             q_push,
	output mtlc_pkg::cmd_t                   q_cmd
);
	import mtlc_pkg::*;

	assign s_tready = q_ready;
	assign q_push   = s_tvalid && q_ready;

	// Decode event code into kind flags, unpack sample fields
	always_comb begin
		q_cmd               = '0;
		q_cmd.temp          = s_tdata[TEMP_W-1:0];
		q_cmd.light         = s_tdata[TEMP_W +: LIGHT_BITS];
		case (s_tuser)
			ACT_NEXT:   q_cmd.kind.step_up = 1'b1;
			ACT_PREV:   q_cmd.kind.step_dn = 1'b1;
			ACT_SELECT: q_cmd.kind.sel     = 1'b1;
			ACT_START:  q_cmd.kind.start   = 1'b1;
			ACT_STOP:   q_cmd.kind.stop    = 1'b1;
			ACT_TEMP:   q_cmd.kind.temp    = 1'b1;
			ACT_LIGHT:  q_cmd.kind.light   = 1'b1;
			default:    q_cmd.kind         = '0;
		endcase
	end

endmodule

/* rtl/core/mtlc_queue.sv */
// Short command queue between front and back end.
module mtlc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mtlc_pkg::cmd_t push_data,
	output logic           in_ready,
	input  logic           pop,
	output mtlc_pkg::cmd_t pop_data,
	output logic           out_valid
);
	import mtlc_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign in_ready  = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign out_valid = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

endmodule

/* rtl/core/mtlc_back.sv */
// Back end: applies events to the controller state and registers the result.
module mtlc_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mtlc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mtlc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            q_valid,
	input  mtlc_pkg::cmd_t                  q_cmd,
	output logic                            q_pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output mtlc_pkg::res_t                  result
);
	import mtlc_pkg::*;

	localparam int SP10_W = TSP_W + 4;
	localparam int CMP_W  = SP10_W + 2;

	// Configuration registers
	logic [DUTY_W-1:0]     duty_q;
	logic [HYST_W-1:0]     hyst_q;
	// Controller state
	logic                  menu_q, sub_q, rd_q, fan_q, lamp_q;
	logic [TSP_W-1:0]      tsp_q;
	logic [LSP_W-1:0]      lsp_q;
	logic [LIGHT_BITS-1:0] level_q;
	// Output register
	logic                  out_valid_q;
	res_t                  res_q;

	logic                  menu_d, sub_d, rd_d, fan_d, lamp_d, strobe_d;
	logic [TSP_W-1:0]      tsp_d;
	logic [LSP_W-1:0]      lsp_d;
	logic [LIGHT_BITS-1:0] level_d;
	logic [SP10_W-1:0]     sp10;
	logic signed [CMP_W-1:0] sp_s, off_s, temp_s;

	assign cfg_ready = 1'b1;
	assign q_pop     = q_valid && (!out_valid_q || m_tready);
	assign m_tvalid  = out_valid_q;
	assign result    = res_q;

	// Setpoint in tenths and fan-off threshold
	always_comb begin
		sp10   = {1'b0, tsp_q, 3'b000} + {3'b000, tsp_q, 1'b0};
		sp_s   = signed'({2'b00, sp10});
		off_s  = sp_s - signed'({{(CMP_W - HYST_W){1'b0}}, hyst_q});
		temp_s = {{(CMP_W - TEMP_W){q_cmd.temp[TEMP_W-1]}}, q_cmd.temp};
	end

	// Next-state for one event
	always_comb begin
		menu_d   = menu_q;
		sub_d    = sub_q;
		rd_d     = rd_q;
		fan_d    = fan_q;
		tsp_d    = tsp_q;
		lsp_d    = lsp_q;
		level_d  = level_q;
		strobe_d = 1'b0;
		if (q_cmd.kind.step_up) begin
			if (sub_q) begin
				if (!menu_q)
					tsp_d = tsp_q + 1'b1;
				else
					lsp_d = lsp_q + 1'b1;
			end else if (!menu_q) begin
				menu_d = 1'b1;
			end
		end else if (q_cmd.kind.step_dn) begin
			if (sub_q) begin
				if (!menu_q)
					tsp_d = tsp_q - 1'b1;
				else
					lsp_d = lsp_q - 1'b1;
			end else if (menu_q) begin
				menu_d = 1'b0;
			end
		end else if (q_cmd.kind.sel) begin
			sub_d    = !sub_q;
			strobe_d = sub_q;
		end else if (q_cmd.kind.start) begin
			rd_d = 1'b1;
		end else if (q_cmd.kind.stop) begin
			rd_d  = 1'b0;
			fan_d = 1'b0;
		end else if (q_cmd.kind.temp) begin
			// bang-bang with hysteresis
			if (rd_q) begin
				if (!fan_q && (temp_s > sp_s))
					fan_d = 1'b1;
				else if (fan_q && (temp_s < off_s))
					fan_d = 1'b0;
			end
		end else if (q_cmd.kind.light) begin
			if (rd_q)
				level_d = q_cmd.light;
		end
		// lamp follows the level only while reading
		lamp_d = lamp_q;
		if (rd_d)
			lamp_d = ({{(LSP_W - LIGHT_BITS){1'b0}}, level_d} < lsp_d);
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= FAN_DUTY_RESET;
			hyst_q <= HYST_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FAN_DUTY: duty_q <= cfg_data[DUTY_W-1:0];
				REG_HYST:     hyst_q <= cfg_data[HYST_W-1:0];
				default:      ;
			endcase
		end
	end

	// State update on each popped request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			menu_q  <= 1'b0;
			sub_q   <= 1'b0;
			rd_q    <= 1'b0;
			fan_q   <= 1'b0;
			lamp_q  <= 1'b0;
			tsp_q   <= TEMP_SP_RESET;
			lsp_q   <= LIGHT_SP_RESET;
			level_q <= '0;
		end else if (q_pop) begin
			menu_q  <= menu_d;
			sub_q   <= sub_d;
			rd_q    <= rd_d;
			fan_q   <= fan_d;
			lamp_q  <= lamp_d;
			tsp_q   <= tsp_d;
			lsp_q   <= lsp_d;
			level_q <= level_d;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (q_pop)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q.menu_number    <= menu_d;
			res_q.submenu_active <= sub_d;
			res_q.temp_target    <= tsp_d;
			res_q.light_target   <= lsp_d;
			res_q.fan_duty       <= fan_d ? duty_q : '0;
			res_q.lamp           <= lamp_d;
			res_q.reading_on     <= rd_d;
			res_q.report_strobe  <= strobe_d;
		end
	end

endmodule

/* rtl/core/menu_thermostat_light_controller_top.sv */
// Top level of the menu thermostat and light controller.
//
//  Channel  Direction  Handshake            Payload
//  s_*      in         s_tvalid/s_tready    s_tuser event code, s_tdata samples
//  m_*      out        m_tvalid/m_tready    m_tdata state report, one per event
//  cfg_*    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One event per cycle sustained while m_tready is high; an accepted event's
// result passes through the command queue and then the output register
// before it is offered on m_tdata.
// arst_n clears controller state and configuration at once, not data registers.
// s_tready drops only when the queue holds two events, i.e. when m_tready is
// held low; cfg_ready is always high.
module menu_thermostat_light_controller_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [11:0] temperature_tenths, [21:12] light_sample, rest zero
	input  logic [mtlc_pkg::IN_DATA_W-1:0]  s_tdata,
	// [2:0] action
	input  logic [mtlc_pkg::ACT_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] menu_number, [1] submenu_active, [9:2] temp_target,
	// [25:10] light_target, [33:26] fan_duty, [34] lamp, [35] reading_on,
	// [36] report_strobe, rest zero
	output logic [mtlc_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mtlc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mtlc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mtlc_pkg::*;

	logic q_ready, q_push, q_valid, q_pop;
	cmd_t push_cmd, pop_cmd;
	res_t result;

	mtlc_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_ready  (q_ready),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	mtlc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_cmd),
		.in_ready  (q_ready),
		.pop       (q_pop),
		.pop_data  (pop_cmd),
		.out_valid (q_valid)
	);

	mtlc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_cmd     (pop_cmd),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.result    (result)
	);

	// Pack result, menu_number (last struct field) lowest
	assign m_tdata = {{(OUT_DATA_W - OUT_BITS){1'b0}}, result};

endmodule

/* rtl/core/mtlc_checker.sv */
// Port-level checks for the controller top, attached by bind.
module mtlc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [mtlc_pkg::OUT_DATA_W-1:0] m_tdata
);
	import mtlc_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Report request only on leaving the submenu
	a_strobe_exit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[36] |-> !m_tdata[1])
		else $error("report request while still in submenu");

	// Fan can only run while reading is enabled
	a_fan_reading: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[33:26] != '0) |-> m_tdata[35])
		else $error("fan duty with reading disabled");

	// Lamp can only change while reading is enabled
	a_lamp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready ##1 m_tvalid && !m_tdata[35] |->
			m_tdata[34] == $past(m_tdata[34]))
		else $error("lamp changed with reading disabled");

endmodule

bind menu_thermostat_light_controller_top mtlc_checker u_mtlc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* tb/tb_top.sv */
// Self-checking testbench for the menu thermostat and light controller top level.
`timescale 1ns / 100ps

module tb_top;
	import mtlc_pkg::*;

	// Codes the package leaves unnamed
	localparam logic [ACT_W-1:0]     ACT_SPARE = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

	// Cycles with no handshake on any channel before the run is abandoned
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_EVENTS = 1300;
	localparam int PHASES = 6;

	// Reports that follow from reset with no sampling enabled
	localparam res_t RESET_REPORT = '{report_strobe: 1'b0, reading_on: 1'b0, lamp: 1'b0,
		fan_duty: 8'd0, light_target: LIGHT_SP_RESET, temp_target: TEMP_SP_RESET,
		submenu_active: 1'b0, menu_number: 1'b0};
	localparam res_t MENU1_REPORT = '{report_strobe: 1'b0, reading_on: 1'b0, lamp: 1'b0,
		fan_duty: 8'd0, light_target: LIGHT_SP_RESET, temp_target: TEMP_SP_RESET,
		submenu_active: 1'b0, menu_number: 1'b1};
	localparam res_t EDIT1_REPORT = '{report_strobe: 1'b0, reading_on: 1'b0, lamp: 1'b0,
		fan_duty: 8'd0, light_target: LIGHT_SP_RESET, temp_target: TEMP_SP_RESET,
		submenu_active: 1'b1, menu_number: 1'b1};

	typedef struct {
		logic [ACT_W-1:0]         act;
		logic signed [TEMP_W-1:0] temp;
		logic [LIGHT_BITS-1:0]    light;
		bit                       fixed;
		res_t                     want;
	} script_row_t;

	// Directed events; rows marked fixed carry a hand-written report
	script_row_t script [26] = '{
		'{ACT_SPARE,  12'sd0,     10'd0,    1'b1, RESET_REPORT},
		'{ACT_PREV,   12'sd0,     10'd0,    1'b1, RESET_REPORT},
		'{ACT_NEXT,   12'sd0,     10'd0,    1'b1, MENU1_REPORT},
		'{ACT_NEXT,   12'sd0,     10'd0,    1'b1, MENU1_REPORT},
		'{ACT_TEMP,   12'sd1500,  10'd1023, 1'b1, MENU1_REPORT},
		'{ACT_LIGHT,  -12'sd2048, 10'd1023, 1'b1, MENU1_REPORT},
		'{ACT_SELECT, 12'sd0,     10'd0,    1'b1, EDIT1_REPORT},
		'{ACT_PREV,   12'sd0,     10'd0,    1'b0, '0},
		'{ACT_NEXT,   12'sd0,     10'd0,    1'b0, '0},
		'{ACT_SELECT, 12'sd0,     10'd0,    1'b0, '0},
		'{ACT_START,  12'sd0,     10'd0,    1'b0, '0},
		'{ACT_LIGHT,  12'sd0,     10'd1023, 1'b0, '0},
		'{ACT_LIGHT,  12'sd2047,  10'd0,    1'b0, '0},
		'{ACT_PREV,   12'sd0,     10'd0,    1'b0, '0},
		'{ACT_TEMP,   12'sd501,   10'd0,    1'b0, '0},
		'{ACT_TEMP,   12'sd490,   10'd0,    1'b0, '0},
		'{ACT_TEMP,   12'sd489,   10'd0,    1'b0, '0},
		'{ACT_TEMP,   -12'sd550,  10'd0,    1'b0, '0},
		'{ACT_TEMP,   -12'sd2048, 10'd0,    1'b0, '0},
		'{ACT_TEMP,   12'sd2047,  10'd0,    1'b0, '0},
		'{ACT_STOP,   12'sd0,     10'd0,    1'b0, '0},
		'{ACT_STOP,   12'sd0,     10'd0,    1'b0, '0},
		'{ACT_LIGHT,  12'sd0,     10'd1023, 1'b0, '0},
		'{ACT_START,  12'sd0,     10'd0,    1'b0, '0},
		'{ACT_START,  12'sd0,     10'd0,    1'b0, '0},
		'{ACT_SPARE,  12'sd0,     10'd0,    1'b0, '0}
	};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic [ACT_W-1:0]      s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Controller mirror: configuration and state
	logic [DUTY_W-1:0]     duty_reg;
	logic [HYST_W-1:0]     hyst_reg;
	logic                  cur_menu;
	logic                  editing;
	logic [TSP_W-1:0]      temp_sp;
	logic [LSP_W-1:0]      light_sp;
	logic                  sampling;
	logic                  fan_on;
	logic [LIGHT_BITS-1:0] light_lvl;
	logic                  lamp_on;

	res_t        pending_reports [$];
	int unsigned mismatches   = 0;
	int unsigned events_sent  = 0;
	int unsigned quiet_cycles = 0;
	int unsigned send_gap_pct   = 0;
	int unsigned recv_stall_pct = 0;

	menu_thermostat_light_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// Apply one event to the mirror and return the state report it gives
	function automatic res_t next_report(input logic [ACT_W-1:0] act,
			input logic signed [TEMP_W-1:0] temp, input logic [LIGHT_BITS-1:0] light);
		res_t r;
		logic strobe;
		int   sp10;
		int   t;
		strobe = 1'b0;
		sp10   = int'(temp_sp) * 10;
		t      = int'(temp);
		case (act)
			ACT_NEXT: begin
				if (editing) begin
					if (cur_menu) light_sp = light_sp + 1'b1;
					else temp_sp = temp_sp + 1'b1;
				end else if (cur_menu == 1'b0) begin
					cur_menu = 1'b1;
				end
			end
			ACT_PREV: begin
				if (editing) begin
					if (cur_menu) light_sp = light_sp - 1'b1;
					else temp_sp = temp_sp - 1'b1;
				end else if (cur_menu == 1'b1) begin
					cur_menu = 1'b0;
				end
			end
			ACT_SELECT: begin
				strobe  = editing;
				editing = !editing;
			end
			ACT_START: sampling = 1'b1;
			ACT_STOP: begin
				sampling = 1'b0;
				fan_on   = 1'b0;
			end
			ACT_TEMP: begin
				if (sampling) begin
					if (t > sp10 && !fan_on) fan_on = 1'b1;
					if (t < sp10 - int'(hyst_reg) && fan_on) fan_on = 1'b0;
				end
			end
			ACT_LIGHT: if (sampling) light_lvl = light;
			default: ;
		endcase
		if (sampling) lamp_on = (light_lvl < light_sp);
		r.menu_number    = cur_menu;
		r.submenu_active = editing;
		r.temp_target    = temp_sp;
		r.light_target   = light_sp;
		r.fan_duty       = fan_on ? duty_reg : '0;
		r.lamp           = lamp_on;
		r.reading_on     = sampling;
		r.report_strobe  = strobe;
		return r;
	endfunction

	// Offer one event, wait for its request to be taken, log the report it should give
	task automatic send_event(input logic [ACT_W-1:0] act, input logic signed [TEMP_W-1:0] temp,
			input logic [LIGHT_BITS-1:0] light, input bit fixed = 1'b0, input res_t want = '0);
		res_t r;
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {{(IN_DATA_W - TEMP_W - LIGHT_BITS){1'b0}}, light, temp};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = next_report(act, temp, light);
		pending_reports.push_back(fixed ? want : r);
		events_sent++;
	endtask

	// Hold the sender off until every report is back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_FAN_DUTY) duty_reg = val;
		else if (idx == REG_HYST) hyst_reg = val;
	endtask

	task automatic set_config(input logic [DUTY_W-1:0] duty, input logic [HYST_W-1:0] hyst);
		wait_idle();
		write_reg(REG_FAN_DUTY, duty);
		write_reg(REG_HYST, hyst);
		// an index with no register behind it must change nothing
		if ($urandom_range(1)) write_reg(REG_SPARE, 8'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Random events: samples near the thresholds, menu moves, start, stop, unused codes and setpoint edit runs
	task automatic random_events(input int unsigned count);
		int unsigned              stop_at;
		int unsigned              pick;
		int unsigned              run;
		int                       spread;
		int                       v;
		logic [ACT_W-1:0]         dir;
		logic signed [TEMP_W-1:0] tv;
		logic [LIGHT_BITS-1:0]    lv;
		stop_at = events_sent + count;
		while (events_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				if ($urandom_range(9) == 0) begin
					tv = 12'($urandom);
				end else begin
					spread = int'(hyst_reg) + 20;
					v = int'(temp_sp) * 10 + int'($urandom_range(2 * spread)) - spread;
					if (v > 2047) v = 2047;
					if (v < -2048) v = -2048;
					tv = v[TEMP_W-1:0];
				end
				send_event(ACT_TEMP, tv, 10'($urandom));
			end else if (pick < 50) begin
				if ($urandom_range(9) == 0) begin
					lv = 10'($urandom);
				end else begin
					v = int'(light_sp) + int'($urandom_range(32)) - 16;
					if (v > 1023) v = 1023;
					if (v < 0) v = 0;
					lv = v[LIGHT_BITS-1:0];
				end
				send_event(ACT_LIGHT, 12'($urandom), lv);
			end else if (pick < 64) begin
				send_event($urandom_range(1) ? ACT_NEXT : ACT_PREV, 12'($urandom), 10'($urandom));
			end else if (pick < 71) begin
				send_event(ACT_SELECT, 12'($urandom), 10'($urandom));
			end else if (pick < 77) begin
				send_event(ACT_START, 12'($urandom), 10'($urandom));
			end else if (pick < 80) begin
				send_event(ACT_STOP, 12'($urandom), 10'($urandom));
			end else if (pick < 83) begin
				send_event(ACT_SPARE, 12'($urandom), 10'($urandom));
			end else begin
				// setpoint edit: enter, step one way, leave with a report strobe
				if (!editing) send_event(ACT_SELECT, 12'($urandom), 10'($urandom));
				run = ($urandom_range(9) == 0) ? $urandom_range(300, 1) : $urandom_range(12, 1);
				dir = $urandom_range(1) ? ACT_NEXT : ACT_PREV;
				repeat (run) send_event(dir, 12'($urandom), 10'($urandom));
				send_event(ACT_SELECT, 12'($urandom), 10'($urandom));
			end
		end
	endtask

	// Result side: random back-pressure and field-by-field comparison
	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : report_check
		res_t got;
		res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata[$bits(res_t)-1:0]);
				if (pending_reports.size() == 0) begin
					$error("report with no request pending: %h", m_tdata);
					mismatches++;
				end else begin
					want = pending_reports.pop_front();
					check_field("menu_number", want.menu_number, got.menu_number);
					check_field("submenu_active", want.submenu_active, got.submenu_active);
					check_field("temp_target", want.temp_target, got.temp_target);
					check_field("light_target", want.light_target, got.light_target);
					check_field("fan_duty", want.fan_duty, got.fan_duty);
					check_field("lamp", want.lamp, got.lamp);
					check_field("reading_on", want.reading_on, got.reading_on);
					check_field("report_strobe", want.report_strobe, got.report_strobe);
					check_field("padding", 0, m_tdata[OUT_DATA_W-1:$bits(res_t)]);
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog on handshake activity
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	// Main sequence
	initial begin
		logic [DUTY_W-1:0] duty_set [PHASES];
		logic [HYST_W-1:0] hyst_set [PHASES];
		duty_set = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd254, 8'd230};
		hyst_set = '{8'd0, 8'd255, 8'd254, 8'd1, 8'd0, 8'd10};
		duty_reg  = FAN_DUTY_RESET;
		hyst_reg  = HYST_RESET;
		cur_menu  = 1'b0;
		editing   = 1'b0;
		temp_sp   = TEMP_SP_RESET;
		light_sp  = LIGHT_SP_RESET;
		sampling  = 1'b0;
		fan_on    = 1'b0;
		light_lvl = '0;
		lamp_on   = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset configuration, sender light, receiver heavy
		send_gap_pct   = 28;
		recv_stall_pct = 71;
		foreach (script[i])
			send_event(script[i].act, script[i].temp, script[i].light, script[i].fixed,
				script[i].want);

		// setpoint wraparound both ways on both menus
		send_event(ACT_SELECT, 12'sd0, 10'd0);
		repeat (51) send_event(ACT_PREV, 12'sd0, 10'd0);
		repeat (2) send_event(ACT_NEXT, 12'sd0, 10'd0);
		send_event(ACT_SELECT, 12'sd0, 10'd0);
		send_event(ACT_NEXT, 12'sd0, 10'd0);
		send_event(ACT_SELECT, 12'sd0, 10'd0);
		repeat (101) send_event(ACT_PREV, 12'sd0, 10'd0);
		repeat (2) send_event(ACT_NEXT, 12'sd0, 10'd0);
		send_event(ACT_SELECT, 12'sd0, 10'd0);

		// random phases, each under its own register setting, with one idle pattern per pair of phases
		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1) set_config(8'($urandom), 8'($urandom));
			else set_config(duty_set[p], hyst_set[p]);
			if (p < 2) begin
				send_gap_pct   = 28;
				recv_stall_pct = 71;
			end else if (p < 4) begin
				send_gap_pct   = 71;
				recv_stall_pct = 28;
			end else begin
				send_gap_pct   = 0;
				recv_stall_pct = 0;
			end
			random_events(RANDOM_EVENTS / PHASES);
		end

		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_reports.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
